[hdl/txtov_pkg.sv]
package txtov_pkg;

  localparam int unsigned MAX_CHARS  = 32;
  localparam int unsigned MAX_SCALE  = 8;
  localparam int unsigned FIRST_CODE = 32;
  localparam int unsigned LAST_CODE  = 90;
  localparam int unsigned GLYPH_COLS = 5;
  localparam int unsigned GLYPH_ROWS = 7;
  localparam int unsigned PITCH_COLS = GLYPH_COLS + 1;

  localparam int unsigned SLOT_W     = $clog2(MAX_CHARS);
  localparam int unsigned CODE_W     = 8;
  localparam int unsigned PIX_W      = 12;
  localparam int unsigned COORD_W    = 13;
  localparam int unsigned DIST_W     = 13;
  localparam int unsigned SCALE_W    = 4;
  localparam int unsigned COLOR_W    = 8;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 13;

  localparam int unsigned FONT_DEPTH = LAST_CODE - FIRST_CODE + 1;
  localparam int unsigned FONT_IDX_W = $clog2(FONT_DEPTH);
  localparam int unsigned COL_W      = $clog2(PITCH_COLS);
  localparam int unsigned ROW_W      = $clog2(GLYPH_ROWS);

  // Reciprocal multiply: floor(n / d) = (n * ceil(2^RCP_SHIFT / d)) >> RCP_SHIFT,
  // exact for n below 2^DIST_W and d up to 15.
  localparam int unsigned RCP_SHIFT  = 17;
  localparam int unsigned RCP_W      = RCP_SHIFT + 1;
  localparam int unsigned PITCH_RCP  = ((1 << RCP_SHIFT) + PITCH_COLS - 1) / PITCH_COLS;
  localparam int unsigned PRCP_W     = $clog2(PITCH_RCP + 1);
  localparam int unsigned IDX_W      = DIST_W - 2;

  localparam logic signed [COORD_W-1:0] RST_ORIGIN = '0;
  localparam logic [SCALE_W-1:0]        RST_SCALE  = SCALE_W'(1);
  localparam logic [COLOR_W-1:0]        RST_COLOR  = COLOR_W'(255);
  localparam logic [COORD_W-1:0]        RST_WIDTH  = COORD_W'(1920);
  localparam logic [COORD_W-1:0]        RST_HEIGHT = COORD_W'(1080);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X     = 4'd0,
    REG_ORIGIN_Y     = 4'd1,
    REG_GLYPH_SCALE  = 4'd2,
    REG_TEXT_BLUE    = 4'd3,
    REG_TEXT_GREEN   = 4'd4,
    REG_TEXT_RED     = 4'd5,
    REG_FRAME_WIDTH  = 4'd6,
    REG_FRAME_HEIGHT = 4'd7
  } cfg_reg_e;

  typedef enum logic {
    MODE_WRITE = 1'b0,
    MODE_QUERY = 1'b1
  } mode_e;

  typedef logic [0:GLYPH_COLS-1][GLYPH_ROWS-1:0] glyph_t;

  // Column bytes hold the top row in bit 0.
  localparam glyph_t FONT_ROM [FONT_DEPTH] = '{
    '{7'h00,7'h00,7'h00,7'h00,7'h00}, '{7'h00,7'h00,7'h5F,7'h00,7'h00},
    '{7'h00,7'h07,7'h00,7'h07,7'h00}, '{7'h14,7'h7F,7'h14,7'h7F,7'h14},
    '{7'h24,7'h2A,7'h7F,7'h2A,7'h12}, '{7'h23,7'h13,7'h08,7'h64,7'h62},
    '{7'h36,7'h49,7'h55,7'h22,7'h50}, '{7'h00,7'h05,7'h03,7'h00,7'h00},
    '{7'h00,7'h1C,7'h22,7'h41,7'h00}, '{7'h00,7'h41,7'h22,7'h1C,7'h00},
    '{7'h08,7'h2A,7'h1C,7'h2A,7'h08}, '{7'h08,7'h08,7'h3E,7'h08,7'h08},
    '{7'h00,7'h50,7'h30,7'h00,7'h00}, '{7'h08,7'h08,7'h08,7'h08,7'h08},
    '{7'h00,7'h60,7'h60,7'h00,7'h00}, '{7'h20,7'h10,7'h08,7'h04,7'h02},
    '{7'h3E,7'h51,7'h49,7'h45,7'h3E}, '{7'h00,7'h42,7'h7F,7'h40,7'h00},
    '{7'h42,7'h61,7'h51,7'h49,7'h46}, '{7'h21,7'h41,7'h45,7'h4B,7'h31},
    '{7'h18,7'h14,7'h12,7'h7F,7'h10}, '{7'h27,7'h45,7'h45,7'h45,7'h39},
    '{7'h3C,7'h4A,7'h49,7'h49,7'h30}, '{7'h01,7'h71,7'h09,7'h05,7'h03},
    '{7'h36,7'h49,7'h49,7'h49,7'h36}, '{7'h06,7'h49,7'h49,7'h29,7'h1E},
    '{7'h00,7'h36,7'h36,7'h00,7'h00}, '{7'h00,7'h56,7'h36,7'h00,7'h00},
    '{7'h08,7'h14,7'h22,7'h41,7'h00}, '{7'h14,7'h14,7'h14,7'h14,7'h14},
    '{7'h00,7'h41,7'h22,7'h14,7'h08}, '{7'h02,7'h01,7'h51,7'h09,7'h06},
    '{7'h32,7'h49,7'h79,7'h41,7'h3E}, '{7'h7E,7'h11,7'h11,7'h11,7'h7E},
    '{7'h7F,7'h49,7'h49,7'h49,7'h36}, '{7'h3E,7'h41,7'h41,7'h41,7'h22},
    '{7'h7F,7'h41,7'h41,7'h22,7'h1C}, '{7'h7F,7'h49,7'h49,7'h49,7'h41},
    '{7'h7F,7'h09,7'h09,7'h09,7'h01}, '{7'h3E,7'h41,7'h49,7'h49,7'h7A},
    '{7'h7F,7'h08,7'h08,7'h08,7'h7F}, '{7'h00,7'h41,7'h7F,7'h41,7'h00},
    '{7'h20,7'h40,7'h41,7'h3F,7'h01}, '{7'h7F,7'h08,7'h14,7'h22,7'h41},
    '{7'h7F,7'h40,7'h40,7'h40,7'h40}, '{7'h7F,7'h02,7'h0C,7'h02,7'h7F},
    '{7'h7F,7'h04,7'h08,7'h10,7'h7F}, '{7'h3E,7'h41,7'h41,7'h41,7'h3E},
    '{7'h7F,7'h09,7'h09,7'h09,7'h06}, '{7'h3E,7'h41,7'h51,7'h21,7'h5E},
    '{7'h7F,7'h09,7'h19,7'h29,7'h46}, '{7'h46,7'h49,7'h49,7'h49,7'h31},
    '{7'h01,7'h01,7'h7F,7'h01,7'h01}, '{7'h3F,7'h40,7'h40,7'h40,7'h3F},
    '{7'h1F,7'h20,7'h40,7'h20,7'h1F}, '{7'h7F,7'h20,7'h18,7'h20,7'h7F},
    '{7'h63,7'h14,7'h08,7'h14,7'h63}, '{7'h07,7'h08,7'h70,7'h08,7'h07},
    '{7'h61,7'h51,7'h49,7'h45,7'h43}
  };

  function automatic logic [RCP_W-1:0] scale_rcp(input logic [SCALE_W-1:0] s);
    logic [RCP_W-1:0] r;
    case (s)
      4'd1:    r = RCP_W'(131072);
      4'd2:    r = RCP_W'(65536);
      4'd3:    r = RCP_W'(43691);
      4'd4:    r = RCP_W'(32768);
      4'd5:    r = RCP_W'(26215);
      4'd6:    r = RCP_W'(21846);
      4'd7:    r = RCP_W'(18725);
      4'd8:    r = RCP_W'(16384);
      4'd9:    r = RCP_W'(14564);
      4'd10:   r = RCP_W'(13108);
      4'd11:   r = RCP_W'(11916);
      4'd12:   r = RCP_W'(10923);
      4'd13:   r = RCP_W'(10083);
      4'd14:   r = RCP_W'(9363);
      4'd15:   r = RCP_W'(8739);
      default: r = '0;
    endcase
    return r;
  endfunction

  // Lowercase shows as uppercase; codes without a glyph show as a space.
  function automatic logic [FONT_IDX_W-1:0] fold_code(input logic [CODE_W-1:0] c);
    logic [CODE_W-1:0] u;
    u = c;
    if (c >= CODE_W'("a") && c <= CODE_W'("z")) begin
      u = c - CODE_W'(32);
    end
    if (u < CODE_W'(FIRST_CODE) || u > CODE_W'(LAST_CODE)) begin
      u = CODE_W'(FIRST_CODE);
    end
    return FONT_IDX_W'(u - CODE_W'(FIRST_CODE));
  endfunction

endpackage

[hdl/txtov_ram.sv]
module txtov_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/scaled_5x7_text_overlay_core.sv]
// Channel   Direction  Handshake                 Beat contents
// command   in         start_i, busy_o           mode_i, slot_i, char_code_i,
//                                                pixel_x_i, pixel_y_i
// result    out        valid_o (strobe)          hit_o, out_blue_o, out_green_o,
//                                                out_red_o
// config    in         cfg_valid_i, cfg_ready_o  cfg_index_i, cfg_data_i
//
// One command beat is taken every cycle; busy_o stays low.
// A pixel query gives its result from the result register after stage 4; a write gives none.
// The five stages end in the text store read and the glyph lookup.
// Reset sets the registers to their defaults and marks every slot as a space.
// The receiver cannot stall, so the result strobe lasts exactly one cycle.
module scaled_5x7_text_overlay_core import txtov_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic                  mode_i,
  input  logic [SLOT_W-1:0]     slot_i,
  input  logic [CODE_W-1:0]     char_code_i,
  input  logic [PIX_W-1:0]      pixel_x_i,
  input  logic [PIX_W-1:0]      pixel_y_i,
  output logic                  valid_o,
  output logic                  hit_o,
  output logic [COLOR_W-1:0]    out_blue_o,
  output logic [COLOR_W-1:0]    out_green_o,
  output logic [COLOR_W-1:0]    out_red_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic signed [COORD_W-1:0] origin_x_q, origin_y_q;
  logic [SCALE_W-1:0]        glyph_scale_q;
  logic [COLOR_W-1:0]        text_blue_q, text_green_q, text_red_q;
  logic [COORD_W-1:0]        frame_width_q, frame_height_q;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q     <= RST_ORIGIN;
      origin_y_q     <= RST_ORIGIN;
      glyph_scale_q  <= RST_SCALE;
      text_blue_q    <= RST_COLOR;
      text_green_q   <= RST_COLOR;
      text_red_q     <= RST_COLOR;
      frame_width_q  <= RST_WIDTH;
      frame_height_q <= RST_HEIGHT;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_ORIGIN_X:     origin_x_q     <= $signed(cfg_data_i[COORD_W-1:0]);
        REG_ORIGIN_Y:     origin_y_q     <= $signed(cfg_data_i[COORD_W-1:0]);
        REG_GLYPH_SCALE:  glyph_scale_q  <= cfg_data_i[SCALE_W-1:0];
        REG_TEXT_BLUE:    text_blue_q    <= cfg_data_i[COLOR_W-1:0];
        REG_TEXT_GREEN:   text_green_q   <= cfg_data_i[COLOR_W-1:0];
        REG_TEXT_RED:     text_red_q     <= cfg_data_i[COLOR_W-1:0];
        REG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i[COORD_W-1:0];
        REG_FRAME_HEIGHT: frame_height_q <= cfg_data_i[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage 0: offsets to the text origin, clipping and scale reciprocal.
  logic                  accept;
  logic signed [DIST_W:0] dx_d, dy_d;
  logic [SCALE_W-1:0]    scale_eff;
  logic                  live_d;

  assign accept = start_i && !busy_o;

  always_comb begin
    dx_d = $signed({2'b00, pixel_x_i}) - $signed({origin_x_q[COORD_W-1], origin_x_q});
    dy_d = $signed({2'b00, pixel_y_i}) - $signed({origin_y_q[COORD_W-1], origin_y_q});
    scale_eff = (glyph_scale_q > SCALE_W'(MAX_SCALE)) ? SCALE_W'(MAX_SCALE)
                                                      : glyph_scale_q;
    live_d = ({1'b0, pixel_x_i} < frame_width_q) && ({1'b0, pixel_y_i} < frame_height_q)
             && (glyph_scale_q != '0) && !dx_d[DIST_W] && !dy_d[DIST_W];
  end

  logic                  s1_vld_q, s2_vld_q, s3_vld_q, s4_vld_q;
  logic                  s1_mode_q, s2_mode_q, s3_mode_q, s4_mode_q;
  logic                  s1_live_q, s2_live_q, s3_live_q;
  logic [DIST_W-1:0]     s1_dx_q, s1_dy_q;
  logic [RCP_W-1:0]      s1_rcp_q;
  logic [SLOT_W-1:0]     s1_slot_q, s2_slot_q, s3_slot_q;
  logic [CODE_W-1:0]     s1_code_q, s2_code_q, s3_code_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= accept;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_mode_q <= mode_i;
    s1_live_q <= live_d;
    s1_dx_q   <= dx_d[DIST_W-1:0];
    s1_dy_q   <= dy_d[DIST_W-1:0];
    s1_rcp_q  <= scale_rcp(scale_eff);
    s1_slot_q <= slot_i;
    s1_code_q <= char_code_i;
  end

  // Stage 1: offsets in font dots.
  logic [DIST_W+RCP_W-1:0] prod_x, prod_y;
  logic [DIST_W-1:0]       s2_ux_q, s2_uy_q;

  assign prod_x = (DIST_W+RCP_W)'(s1_dx_q) * (DIST_W+RCP_W)'(s1_rcp_q);
  assign prod_y = (DIST_W+RCP_W)'(s1_dy_q) * (DIST_W+RCP_W)'(s1_rcp_q);

  always_ff @(posedge clk_i) begin
    s2_mode_q <= s1_mode_q;
    s2_live_q <= s1_live_q;
    s2_ux_q   <= prod_x[RCP_SHIFT +: DIST_W];
    s2_uy_q   <= prod_y[RCP_SHIFT +: DIST_W];
    s2_slot_q <= s1_slot_q;
    s2_code_q <= s1_code_q;
  end

  // Stage 2: character index from the dot column, and the row check.
  logic [DIST_W+PRCP_W-1:0] prod_i;
  logic [IDX_W-1:0]         s3_idx_q;
  logic [DIST_W-1:0]        s3_ux_q;
  logic                     s3_row_ok_q;
  logic [ROW_W-1:0]         s3_row_q;

  assign prod_i = (DIST_W+PRCP_W)'(s2_ux_q) * (DIST_W+PRCP_W)'(PITCH_RCP);

  always_ff @(posedge clk_i) begin
    s3_mode_q   <= s2_mode_q;
    s3_live_q   <= s2_live_q;
    s3_idx_q    <= prod_i[RCP_SHIFT +: IDX_W];
    s3_ux_q     <= s2_ux_q;
    s3_row_ok_q <= s2_uy_q < DIST_W'(GLYPH_ROWS);
    s3_row_q    <= s2_uy_q[ROW_W-1:0];
    s3_slot_q   <= s2_slot_q;
    s3_code_q   <= s2_code_q;
  end

  // Stage 3: glyph column, text store access.
  logic [DIST_W-1:0]    col_full;
  logic                 geom_d;
  logic                 ram_we;
  logic [CODE_W-1:0]    ram_rdata;
  logic [MAX_CHARS-1:0] slot_vld_q;
  logic                 s4_slot_vld_q;
  logic                 s4_geom_q;
  logic [COL_W-1:0]     s4_col_q;
  logic [ROW_W-1:0]     s4_row_q;

  assign col_full = s3_ux_q - (DIST_W'({s3_idx_q, 2'b00}) + DIST_W'({s3_idx_q, 1'b0}));
  assign geom_d   = s3_live_q && s3_row_ok_q && (s3_idx_q < IDX_W'(MAX_CHARS))
                    && (col_full < DIST_W'(GLYPH_COLS));
  assign ram_we   = s3_vld_q && (s3_mode_q == MODE_WRITE);

  txtov_ram #(
    .Width (CODE_W),
    .Depth (MAX_CHARS)
  ) u_text_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s3_slot_q),
    .wdata_i (s3_code_q),
    .raddr_i (s3_idx_q[SLOT_W-1:0]),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_vld_q <= '0;
    end else if (ram_we) begin
      slot_vld_q[s3_slot_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    s4_mode_q     <= s3_mode_q;
    s4_geom_q     <= geom_d;
    s4_col_q      <= col_full[COL_W-1:0];
    s4_row_q      <= s3_row_q;
    s4_slot_vld_q <= slot_vld_q[s3_idx_q[SLOT_W-1:0]];
  end

  // Stage 4: glyph lookup and result register.
  logic [CODE_W-1:0]     code_rd;
  logic [FONT_IDX_W-1:0] font_idx;
  glyph_t                glyph;
  logic                  hit_d;
  logic                  valid_q, hit_q;
  logic [COLOR_W-1:0]    blue_q, green_q, red_q;

  always_comb begin
    code_rd  = s4_slot_vld_q ? ram_rdata : CODE_W'(FIRST_CODE);
    font_idx = fold_code(code_rd);
    glyph    = FONT_ROM[font_idx];
    hit_d    = s4_geom_q && (s4_col_q < COL_W'(GLYPH_COLS)) && glyph[s4_col_q][s4_row_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= s4_vld_q && (s4_mode_q == MODE_QUERY);
    end
  end

  always_ff @(posedge clk_i) begin
    hit_q   <= hit_d;
    blue_q  <= hit_d ? text_blue_q  : '0;
    green_q <= hit_d ? text_green_q : '0;
    red_q   <= hit_d ? text_red_q   : '0;
  end

  assign valid_o     = valid_q;
  assign hit_o       = hit_q;
  assign out_blue_o  = blue_q;
  assign out_green_o = green_q;
  assign out_red_o   = red_q;

  a_query_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && mode_i == MODE_QUERY) |-> ##5 valid_o)
    else $error("pixel query produced no result");

  a_result_has_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start_i && !busy_o && mode_i == MODE_QUERY, 5))
    else $error("result without a matching pixel query");

  a_write_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && mode_i == MODE_WRITE) |-> ##5 !valid_o)
    else $error("slot write produced a result");

  a_hit_colors: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && hit_o) |-> (out_blue_o == text_blue_q && out_red_o == text_red_q))
    else $error("hit result carries a stale text color");

endmodule
